/* design/krit_pkg.sv */
// Package for the key record index table.
// Holds entry and result types, action and status codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package krit_pkg;

    localparam int unsigned ACT_W   = 3;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned PAGE_W  = 32;
    localparam int unsigned SLOT_W  = 16;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned KTYPE_W = 2;

    // Key comparison rules; the spare code compares as integer.
    localparam logic [KTYPE_W-1:0] KT_INT   = 2'd0;
    localparam logic [KTYPE_W-1:0] KT_FLOAT = 2'd1;
    // Key comparison rule that makes any two nonzero keys equal.
    localparam logic [KTYPE_W-1:0] KT_BOOL  = 2'd2;
    localparam logic [KTYPE_W-1:0] KT_SPARE = 2'd3;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_SORT   = 3'd4,
        ACT_SCAN   = 3'd5,
        ACT_RSVD6  = 3'd6,
        ACT_RSVD7  = 3'd7
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_MORE   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOC_RD,
        S_LOC_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_SRT_RD_I,
        S_SRT_LD_I,
        S_SRT_RD_J,
        S_SRT_CMP,
        S_SCAN_RD,
        S_SCAN_LD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PAGE_W-1:0]  page;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_result;

    // Outcome of the shared key comparator.
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

/* design/krit_in_if.sv */
// Input and output channel interfaces of the key record index table.
// Depends on krit_pkg for the field widths.
`timescale 1ns / 1ps

interface krit_in_if;
    import krit_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [ACT_W-1:0]          action;
    logic signed [KEY_W-1:0]   key_value;
    logic [PAGE_W-1:0]         rid_page_in;
    logic [SLOT_W-1:0]         rid_slot_in;

    modport source (output valid, action, key_value, rid_page_in, rid_slot_in,
                    input ready);
    modport sink   (input valid, action, key_value, rid_page_in, rid_slot_in,
                    output ready);
endinterface

interface krit_out_if;
    import krit_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [PAGE_W-1:0]    rid_page_out;
    logic [SLOT_W-1:0]    rid_slot_out;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, status, rid_page_out, rid_slot_out, entry_count,
                    input ready);
    modport sink   (input valid, status, rid_page_out, rid_slot_out, entry_count,
                    output ready);
endinterface

/* design/krit_mem.sv */
// Entry store: one write port and one read port with registered read data.
// Depends on krit_pkg for the entry type.
`timescale 1ns / 1ps

module krit_mem #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  krit_pkg::t_entry           i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output krit_pkg::t_entry           o_rdata
);
    import krit_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/krit_cmp.sv */
// Shared key comparator: equality under the key rule and signed less-than.
// Depends on krit_pkg.
`timescale 1ns / 1ps

module krit_cmp (
    input  logic [krit_pkg::KEY_W-1:0]   i_a,
    input  logic [krit_pkg::KEY_W-1:0]   i_b,
    input  logic [krit_pkg::KTYPE_W-1:0] i_key_type,
    output krit_pkg::t_cmp               o_cmp
);
    import krit_pkg::*;

    // Boolean keys match when both are zero or both are nonzero.
    always_comb begin
        if (i_key_type == KT_BOOL) begin
            o_cmp.eq = ((|i_a) == (|i_b));
        end else begin
            o_cmp.eq = (i_a == i_b);
        end
        o_cmp.lt = ($signed(i_a) < $signed(i_b));
    end

endmodule

/* design/krit_ctrl.sv */
// Sequencer of the key record index table: walks the entry store for
// lookups, delete shifts, insertion sort and scans. Uses krit_pkg and krit_cmp.
`timescale 1ns / 1ps

module krit_ctrl #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [krit_pkg::KTYPE_W-1:0] i_cfg_wdata,
    krit_in_if.sink                      i_in,
    output logic                         o_mem_we,
    output logic [$clog2(ENTRIES)-1:0]   o_mem_waddr,
    output krit_pkg::t_entry             o_mem_wdata,
    output logic [$clog2(ENTRIES)-1:0]   o_mem_raddr,
    input  krit_pkg::t_entry             i_mem_rdata,
    output logic                         o_res_valid,
    output krit_pkg::t_result            o_res,
    input  logic                         i_res_take
);
    import krit_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    t_state              r_state, n_state;
    logic [ACT_W-1:0]    r_act, n_act;
    t_entry              r_in, n_in;
    t_entry              r_tmp, n_tmp;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_scan, n_scan;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [PAGE_W-1:0]   r_rpage, n_rpage;
    logic [SLOT_W-1:0]   r_rslot, n_rslot;
    logic [KTYPE_W-1:0]  r_ktype;
    logic                sorting;
    t_cmp                cmp;
    logic [CW-1:0]       i_next;
    logic [CW-1:0]       j_prev;

    assign sorting = (r_state == S_SRT_CMP);
    assign i_next  = r_i + 1'b1;
    assign j_prev  = r_j - 1'b1;

    krit_cmp u_cmp (
        .i_a        (sorting ? r_tmp.key : r_in.key),
        .i_b        (i_mem_rdata.key),
        .i_key_type (r_ktype),
        .o_cmp      (cmp)
    );

    // Key rule register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ktype <= '0;
        end else if (i_cfg_we) begin
            r_ktype <= i_cfg_wdata;
        end
    end

    // Sequencer and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_scan  <= n_scan;
        end
        r_act    <= n_act;
        r_in     <= n_in;
        r_tmp    <= n_tmp;
        r_i      <= n_i;
        r_j      <= n_j;
        r_status <= n_status;
        r_rpage  <= n_rpage;
        r_rslot  <= n_rslot;
    end

    // Next state, store accesses and result.
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_in        = r_in;
        n_tmp       = r_tmp;
        n_cnt       = r_cnt;
        n_scan      = r_scan;
        n_i         = r_i;
        n_j         = r_j;
        n_status    = r_status;
        n_rpage     = r_rpage;
        n_rslot     = r_rslot;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_i[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_i[AW-1:0];
        i_in.ready  = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_act    = i_in.action;
                    n_in     = '{key: i_in.key_value, page: i_in.rid_page_in,
                                 slot: i_in.rid_slot_in};
                    n_status = ST_OK;
                    n_rpage  = '0;
                    n_rslot  = '0;
                    n_i      = '0;
                    case (i_in.action)
                        ACT_CLEAR: begin
                            n_cnt   = '0;
                            n_scan  = '0;
                            n_state = S_DONE;
                        end
                        ACT_INSERT, ACT_FIND, ACT_DELETE: begin
                            n_state = S_LOC_RD;
                        end
                        ACT_SORT, ACT_SCAN: begin
                            n_i     = CW'(1);
                            n_state = S_SRT_RD_I;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Linear search: issue a read, then compare the stored key.
            S_LOC_RD: begin
                if (r_i == r_cnt) begin
                    n_state = S_DONE;
                    if (r_act == ACT_INSERT) begin
                        if (r_cnt == FULL) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_cnt[AW-1:0];
                            o_mem_wdata = r_in;
                            n_cnt       = r_cnt + 1'b1;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    n_state = S_LOC_CMP;
                end
            end

            S_LOC_CMP: begin
                if (cmp.eq) begin
                    case (r_act)
                        ACT_INSERT: begin
                            n_status = ST_EXISTS;
                            n_state  = S_DONE;
                        end
                        ACT_FIND: begin
                            n_rpage = i_mem_rdata.page;
                            n_rslot = i_mem_rdata.slot;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DEL_RD;
                        end
                    endcase
                end else begin
                    n_i     = i_next;
                    n_state = S_LOC_RD;
                end
            end

            // Delete: move every later entry down one place.
            S_DEL_RD: begin
                o_mem_raddr = i_next[AW-1:0];
                if (i_next >= r_cnt) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DEL_WR;
                end
            end

            S_DEL_WR: begin
                o_mem_we = 1'b1;
                n_i      = i_next;
                n_state  = S_DEL_RD;
            end

            // Insertion sort, outer step: fetch entry i.
            S_SRT_RD_I: begin
                if (r_i >= r_cnt) begin
                    n_state = (r_act == ACT_SCAN) ? S_SCAN_RD : S_DONE;
                end else begin
                    n_state = S_SRT_LD_I;
                end
            end

            S_SRT_LD_I: begin
                n_tmp   = i_mem_rdata;
                n_j     = r_i;
                n_state = S_SRT_RD_J;
            end

            // Inner step: fetch entry j-1 or drop the held entry at j.
            S_SRT_RD_J: begin
                o_mem_raddr = j_prev[AW-1:0];
                o_mem_waddr = r_j[AW-1:0];
                if (r_j == '0) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = r_tmp;
                    n_i         = i_next;
                    n_state     = S_SRT_RD_I;
                end else begin
                    n_state = S_SRT_CMP;
                end
            end

            S_SRT_CMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[AW-1:0];
                if (cmp.lt) begin
                    n_j     = j_prev;
                    n_state = S_SRT_RD_J;
                end else begin
                    o_mem_wdata = r_tmp;
                    n_i         = i_next;
                    n_state     = S_SRT_RD_I;
                end
            end

            // Scan: return the entry at the scan position.
            S_SCAN_RD: begin
                o_mem_raddr = r_scan[AW-1:0];
                if (r_scan >= r_cnt) begin
                    n_status = ST_NO_MORE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN_LD;
                end
            end

            S_SCAN_LD: begin
                n_rpage = i_mem_rdata.page;
                n_rslot = i_mem_rdata.slot;
                n_scan  = r_scan + 1'b1;
                n_state = S_DONE;
            end

            // Hold the result until the output register takes it.
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = '{status: r_status, page: r_rpage, slot: r_rslot,
                     count: COUNT_W'(r_cnt)};

endmodule

/* design/key_record_index_table.sv */
// Top level of the key record index table.
// Instantiates krit_mem and krit_ctrl; uses krit_pkg and the channel interfaces.
`timescale 1ns / 1ps

// Usage:
// Each input transaction carries an action (clear, insert, find, delete,
// sort, scan next), a key and a record id. Each one yields exactly one
// output transaction with a status, the page and slot of a found or scanned
// entry, and the entry count after the action.
// Latency depends on the action and the number of stored entries. Clear
// and unused actions go straight to the result. Insert, find and delete
// walk the store entry by entry (read, then compare); a delete then moves
// each later entry down. Sort and scan run an insertion sort over the
// single read port, one comparison at a time, and a scan then reads the
// entry at the scan position.
// One transaction is worked on at a time; the input is ready only while the
// sequencer is idle. The result goes to an output register, so the next
// transaction may be accepted while a result waits; a stalled receiver
// holds the sequencer only when a second result is finished. Reset clears the
// entry count, scan position, key rule and output valid. The user must write
// the key rule register with i_cfg_we only while idle; this is not enforced.

module key_record_index_table #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [krit_pkg::KTYPE_W-1:0] i_cfg_wdata,
    krit_in_if.sink                      i_in,
    krit_out_if.source                   o_out
);
    import krit_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    logic          res_valid;
    logic          res_take;
    t_result       res;
    logic          r_ovalid;
    t_result       r_ores;

    krit_mem #(.ENTRIES(ENTRIES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    krit_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // Output register: loads when empty or when its transaction completes.
    assign res_take = res_valid && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_ores <= res;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ores.status;
    assign o_out.rid_page_out = r_ores.page;
    assign o_out.rid_slot_out = r_ores.slot;
    assign o_out.entry_count  = r_ores.count;

    // A taken result is shown in the next cycle.
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> o_out.valid)
        else $error("taken result not presented");

    // Only a successful find or scan returns a record id.
    a_zero_rid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |->
        (o_out.rid_page_out == '0 && o_out.rid_slot_out == '0))
        else $error("record id on a failed action");

    // The sequencer never takes input while a result is pending in it.
    a_no_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !i_in.ready)
        else $error("input accepted while result pending");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule
